// ===== sv/graph_bfs_dfs_traversal_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the graph traversal block
// Implication checks on a clock with a synchronous reset that disables them.
// ---------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH

// same-cycle implication
`define GBT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("graph traversal check failed");

// next-cycle implication
`define GBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("graph traversal check failed");

`endif

// ===== sv/gbt_pkg.sv =====
// ---------------------------------------------------------------------------
// gbt_pkg
// Shared types, codes and helpers of the graph traversal block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbt_pkg;

  localparam int VERT_W           = 6;   // vertex fields
  localparam int CNT_W            = 7;   // vertex_count register
  localparam int OP_W             = 3;
  localparam int MAX_VERTICES_DEF = 64;
  localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE    = 3'd0,
    OP_REMOVE_EDGE = 3'd1,
    OP_REMOVE_VERT = 3'd2,
    OP_DFS         = 3'd3,
    OP_BFS         = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDIT_RD,
    ST_EDIT_WR,
    ST_DFS_PICK,
    ST_DFS_POP,
    ST_BFS_SCAN,
    ST_BFS_DEQ,
    ST_FLUSH
  } state_t;

  // index of the lowest set bit; isolate it with one add, then encode
  function automatic logic [VERT_W-1:0] lowest_index(input logic [63:0] w);
    logic [63:0]       iso;
    logic [VERT_W-1:0] idx;
    iso = w & (~w + 64'd1);
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      if (iso[i]) begin
        idx = idx | i[VERT_W-1:0];
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/gbt_adj_mem.sv =====
// ---------------------------------------------------------------------------
// gbt_adj_mem
// Adjacency row memory, one registered read port and one write port.
// Per-row valid bits make the whole matrix read as cleared after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbt_adj_mem #(
  parameter int MAX_VERTICES = gbt_pkg::MAX_VERTICES_DEF,
  parameter int IDX_W        = $clog2(MAX_VERTICES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic [MAX_VERTICES-1:0] rd_data,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic [MAX_VERTICES-1:0] wr_data
);

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] rd_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= row_valid[rd_addr];
      end
    end
  end

  // a row never written reads as zero
  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// ===== sv/graph_bfs_dfs_traversal.sv =====
// ---------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// Undirected adjacency bit matrix with edge edits and DFS / BFS traversal.
// ---------------------------------------------------------------------------
// Usage:
//  - Input items (op, vertex_a, vertex_b) on in_valid/in_ready. One item is
//    worked on at a time; in_ready is high only while the block is idle.
//  - Add or remove edge: read-modify-write of both rows, no output item.
//    Remove vertex: a read-modify-write sweep of every row, no output.
//  - DFS / BFS: one output item (vertex, last) per visited vertex on
//    out_valid/out_ready, last set on the final one. The adjacency memory has
//    one read port and each step reads one row: DFS reads one row per visited
//    vertex and one per backtrack, BFS one per dequeued vertex.
//  - Each vertex is held one step before it is sent, so the last flag is
//    known; the output register frees the input side while a result waits.
//  - A stalled receiver freezes the traversal at its next emit; no item is
//    lost or dropped.
//  - vertex_count is written on cfg_valid (cfg_ready always high); idle only is up to the user, unenforced.
//  - Reset (rst, synchronous) clears the matrix at once via row valid bits,
//    restores vertex_count to 64 and drops any pending output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES = gbt_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input items
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gbt_pkg::OP_W-1:0]   op,
  input  logic [gbt_pkg::VERT_W-1:0] vertex_a,
  input  logic [gbt_pkg::VERT_W-1:0] vertex_b,
  // result items
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gbt_pkg::VERT_W-1:0] vertex,
  output logic                       last,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gbt_pkg::CNT_W-1:0]  vertex_count
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int TOP_W = $clog2(MAX_VERTICES + 1);
  localparam int VW    = gbt_pkg::VERT_W;
  localparam int CW    = gbt_pkg::CNT_W;
  localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);

  gbt_pkg::state_t state, state_next;

  // configuration
  logic [CW-1:0] scan_count;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_count <= gbt_pkg::VCOUNT_RESET;
    end else if (cfg_valid) begin
      scan_count <= vertex_count;
    end
  end

  // vertices scanned during traversal and removal
  logic [MAX_VERTICES-1:0] scan_mask;
  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      scan_mask[j] = (CW'(j) < scan_count);
    end
  end

  // latched item
  logic [gbt_pkg::OP_W-1:0] op_q;
  logic [VW-1:0]            a_q, b_q;

  // traversal state
  logic [MAX_VERTICES-1:0] visited, visited_next;
  logic [TOP_W-1:0]        top, top_next;        // DFS stack depth
  logic [IDX_W-1:0]        head, head_next;      // BFS queue pointers
  logic [IDX_W-1:0]        tail, tail_next;
  logic [VW-1:0]           pend, pend_next;      // vertex held for last flag
  logic                    pend_valid, pend_valid_next;
  logic [IDX_W-1:0]        edit_idx, edit_idx_next;
  logic                    edit_second, edit_second_next;

  // adjacency memory ports
  logic                    adj_rd_en, adj_wr_en;
  logic [IDX_W-1:0]        adj_rd_addr, adj_wr_addr;
  logic [MAX_VERTICES-1:0] adj_rd_row, adj_wr_row;

  // stack / queue memory (DFS stack and BFS queue never live together)
  logic [VW-1:0]    trav_mem [MAX_VERTICES];
  logic             trav_wr_en, trav_rd_en;
  logic [IDX_W-1:0] trav_wr_addr, trav_rd_addr;
  logic [VW-1:0]    trav_wr_data, trav_rd_data;

  always_ff @(posedge clk) begin
    if (trav_wr_en) begin
      trav_mem[trav_wr_addr] <= trav_wr_data;
    end
    if (trav_rd_en) begin
      trav_rd_data <= trav_mem[trav_rd_addr];
    end
  end

  gbt_adj_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .IDX_W        (IDX_W)
  ) u_adj (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (adj_rd_en),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_row),
    .wr_en   (adj_wr_en),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_row)
  );

  // candidates: neighbours in range and not yet marked
  logic [MAX_VERTICES-1:0] cand;
  logic                    cand_any;
  logic [VW-1:0]           pick;
  logic [IDX_W-1:0]        pick_idx;
  logic [TOP_W-1:0]        top_less2;

  assign cand      = adj_rd_row & scan_mask & ~visited;
  assign cand_any  = |cand;
  assign pick      = gbt_pkg::lowest_index(64'(cand));
  assign pick_idx  = IDX_W'(pick);
  assign top_less2 = top - TOP_W'(2);

  logic out_free;
  assign out_free = !out_valid || out_ready;

  logic a_ok, b_ok;
  assign a_ok = (CW'(vertex_a) < CW'(MAX_VERTICES));
  assign b_ok = (CW'(vertex_b) < CW'(MAX_VERTICES));

  logic is_edge_op;
  assign is_edge_op = (op_q == gbt_pkg::OP_ADD_EDGE) || (op_q == gbt_pkg::OP_REMOVE_EDGE);

  logic edit_done;
  assign edit_done = is_edge_op ? edit_second : (edit_idx == IDX_W'(MAX_VERTICES - 1));

  assign in_ready = (state == gbt_pkg::ST_IDLE);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      gbt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (op)
            gbt_pkg::OP_ADD_EDGE, gbt_pkg::OP_REMOVE_EDGE: begin
              if (a_ok && b_ok) state_next = gbt_pkg::ST_EDIT_RD;
            end
            gbt_pkg::OP_REMOVE_VERT: begin
              if (a_ok) state_next = gbt_pkg::ST_EDIT_RD;
            end
            gbt_pkg::OP_DFS: begin
              if (a_ok) state_next = gbt_pkg::ST_DFS_PICK;
            end
            gbt_pkg::OP_BFS: begin
              if (a_ok) state_next = gbt_pkg::ST_BFS_SCAN;
            end
            default: state_next = gbt_pkg::ST_IDLE;
          endcase
        end
      end
      gbt_pkg::ST_EDIT_RD: state_next = gbt_pkg::ST_EDIT_WR;
      gbt_pkg::ST_EDIT_WR: begin
        state_next = edit_done ? gbt_pkg::ST_IDLE : gbt_pkg::ST_EDIT_RD;
      end
      gbt_pkg::ST_DFS_PICK: begin
        if (!cand_any) begin
          state_next = (top == TOP_W'(1)) ? gbt_pkg::ST_FLUSH : gbt_pkg::ST_DFS_POP;
        end
      end
      gbt_pkg::ST_DFS_POP: state_next = gbt_pkg::ST_DFS_PICK;
      gbt_pkg::ST_BFS_SCAN: begin
        if (!cand_any) begin
          state_next = (head == tail) ? gbt_pkg::ST_FLUSH : gbt_pkg::ST_BFS_DEQ;
        end
      end
      gbt_pkg::ST_BFS_DEQ: begin
        if (out_free) state_next = gbt_pkg::ST_BFS_SCAN;
      end
      gbt_pkg::ST_FLUSH: begin
        if (out_free) state_next = gbt_pkg::ST_IDLE;
      end
      default: state_next = gbt_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath control ----------------
  logic          emit, flush;
  logic [VW-1:0] emit_vertex;
  logic [VW-1:0] edit_other;
  logic [MAX_VERTICES-1:0] edge_bit, col_bit, row_clr;

  assign edit_other = edit_second ? a_q : b_q;
  assign edge_bit   = ROW_ONE << IDX_W'(edit_other);
  // vertex removal: column bit for rows in range, scanned range of its own row
  assign col_bit    = (CW'(edit_idx) < scan_count) ? (ROW_ONE << IDX_W'(a_q)) : '0;
  assign row_clr    = (edit_idx == IDX_W'(a_q)) ? scan_mask : '0;

  always_comb begin
    adj_rd_en        = 1'b0;
    adj_rd_addr      = '0;
    adj_wr_en        = 1'b0;
    adj_wr_addr      = edit_idx;
    adj_wr_row       = '0;
    trav_wr_en       = 1'b0;
    trav_wr_addr     = '0;
    trav_wr_data     = '0;
    trav_rd_en       = 1'b0;
    trav_rd_addr     = '0;
    emit             = 1'b0;
    emit_vertex      = pick;
    flush            = 1'b0;
    visited_next     = visited;
    top_next         = top;
    head_next        = head;
    tail_next        = tail;
    pend_next        = pend;
    pend_valid_next  = pend_valid;
    edit_idx_next    = edit_idx;
    edit_second_next = edit_second;

    unique case (state)
      gbt_pkg::ST_IDLE: begin
        if (in_valid && a_ok) begin
          case (op)
            gbt_pkg::OP_ADD_EDGE, gbt_pkg::OP_REMOVE_EDGE: begin
              edit_idx_next    = IDX_W'(vertex_a);
              edit_second_next = 1'b0;
            end
            gbt_pkg::OP_REMOVE_VERT: begin
              edit_idx_next    = '0;
              edit_second_next = 1'b0;
            end
            gbt_pkg::OP_DFS: begin
              visited_next    = ROW_ONE << IDX_W'(vertex_a);
              trav_wr_en      = 1'b1;
              trav_wr_addr    = '0;
              trav_wr_data    = vertex_a;
              top_next        = TOP_W'(1);
              pend_next       = vertex_a;
              pend_valid_next = 1'b1;
              adj_rd_en       = 1'b1;
              adj_rd_addr     = IDX_W'(vertex_a);
            end
            gbt_pkg::OP_BFS: begin
              // start vertex is dequeued at once
              visited_next    = ROW_ONE << IDX_W'(vertex_a);
              head_next       = '0;
              tail_next       = '0;
              pend_next       = vertex_a;
              pend_valid_next = 1'b1;
              adj_rd_en       = 1'b1;
              adj_rd_addr     = IDX_W'(vertex_a);
            end
            default: ;
          endcase
        end
      end
      gbt_pkg::ST_EDIT_RD: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = edit_idx;
      end
      gbt_pkg::ST_EDIT_WR: begin
        adj_wr_en = 1'b1;
        if (op_q == gbt_pkg::OP_ADD_EDGE) begin
          adj_wr_row = adj_rd_row | edge_bit;
        end else if (op_q == gbt_pkg::OP_REMOVE_EDGE) begin
          adj_wr_row = adj_rd_row & ~edge_bit;
        end else begin
          adj_wr_row = adj_rd_row & ~col_bit & ~row_clr;
        end
        if (is_edge_op) begin
          edit_second_next = 1'b1;
          edit_idx_next    = IDX_W'(b_q);
        end else if (!edit_done) begin
          edit_idx_next = edit_idx + IDX_W'(1);
        end
      end
      gbt_pkg::ST_DFS_PICK: begin
        if (cand_any) begin
          if (out_free) begin
            // descend: push and read the child's row
            emit         = 1'b1;
            emit_vertex  = pick;
            trav_wr_en   = 1'b1;
            trav_wr_addr = top[IDX_W-1:0];
            trav_wr_data = pick;
            top_next     = top + TOP_W'(1);
            visited_next = visited | (ROW_ONE << pick_idx);
            adj_rd_en    = 1'b1;
            adj_rd_addr  = pick_idx;
          end
        end else begin
          // backtrack: fetch the parent frame
          top_next     = top - TOP_W'(1);
          trav_rd_en   = (top != TOP_W'(1));
          trav_rd_addr = top_less2[IDX_W-1:0];
        end
      end
      gbt_pkg::ST_DFS_POP: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = IDX_W'(trav_rd_data);
      end
      gbt_pkg::ST_BFS_SCAN: begin
        if (cand_any) begin
          // queue one neighbour a cycle, marked as it is queued
          trav_wr_en   = 1'b1;
          trav_wr_addr = tail;
          trav_wr_data = pick;
          tail_next    = tail + IDX_W'(1);
          visited_next = visited | (ROW_ONE << pick_idx);
        end else if (head != tail) begin
          trav_rd_en   = 1'b1;
          trav_rd_addr = head;
        end
      end
      gbt_pkg::ST_BFS_DEQ: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_vertex = trav_rd_data;
          head_next   = head + IDX_W'(1);
          adj_rd_en   = 1'b1;
          adj_rd_addr = IDX_W'(trav_rd_data);
        end
      end
      gbt_pkg::ST_FLUSH: begin
        if (out_free) begin
          flush           = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      default: ;
    endcase

    if (emit) begin
      pend_next = emit_vertex;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= gbt_pkg::ST_IDLE;
      visited     <= '0;
      top         <= '0;
      head        <= '0;
      tail        <= '0;
      pend_valid  <= 1'b0;
      edit_idx    <= '0;
      edit_second <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      visited     <= visited_next;
      top         <= top_next;
      head        <= head_next;
      tail        <= tail_next;
      pend_valid  <= pend_valid_next;
      edit_idx    <= edit_idx_next;
      edit_second <= edit_second_next;
      if (emit || flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (in_valid && in_ready) begin
      op_q <= op;
      a_q  <= vertex_a;
      b_q  <= vertex_b;
    end
    // held vertex goes out when its successor appears, or at the end
    if (emit || flush) begin
      vertex <= pend;
      last   <= flush;
    end
  end

  // ---------------- assertions ----------------
  `include "graph_bfs_dfs_traversal_assert.svh"

  `GBT_ASSERT_IMPL(a_idle_no_pending, clk, rst, in_ready, !pend_valid)
  `GBT_ASSERT_IMPL(a_stack_bound, clk, rst, 1'b1, top <= TOP_W'(MAX_VERTICES))
  `GBT_ASSERT_NEXT(a_flush_last, clk, rst, (state == gbt_pkg::ST_FLUSH) && out_free, out_valid && last)
  `GBT_ASSERT_IMPL(a_queue_order, clk, rst, (state == gbt_pkg::ST_BFS_SCAN) || (state == gbt_pkg::ST_BFS_DEQ), head <= tail)

endmodule

// ===== tb/sv/graph_bfs_dfs_traversal_chk.sv =====
// ---------------------------------------------------------------------------
// gbt_visit_checker
// Watches the item, result and config channels of the traversal block, keeps
// its own adjacency matrix and vertex_count copy, predicts each visiting
// order and compares every result item against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbt_visit_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [gbt_pkg::OP_W-1:0]   op,
  input  logic [gbt_pkg::VERT_W-1:0] vertex_a,
  input  logic [gbt_pkg::VERT_W-1:0] vertex_b,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [gbt_pkg::VERT_W-1:0] vertex,
  input  logic                       last,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [gbt_pkg::CNT_W-1:0]  vertex_count,
  output int                         mismatches,
  output int                         pending
);

  typedef struct packed {
    logic [gbt_pkg::VERT_W-1:0] vertex;
    logic                       last;
  } visit_t;

  logic [63:0]                adj [64];
  logic [gbt_pkg::CNT_W-1:0]  vcount;
  visit_t                     visit_q [$];

  // scratch for the order of one traversal
  logic [gbt_pkg::VERT_W-1:0] walk_seq [64];
  int                         walk_len;

  // vertex_count above 64 acts as 64
  function automatic int scan_limit();
    return (vcount > 7'd64) ? 64 : int'(vcount);
  endfunction

  function automatic logic [63:0] scan_bits();
    int c;
    c = scan_limit();
    return (c >= 64) ? '1 : ((64'd1 << c) - 64'd1);
  endfunction

  // depth-first preorder with an explicit stack of (vertex, next index) frames
  task automatic walk_depth_first(input logic [gbt_pkg::VERT_W-1:0] start);
    logic [63:0] mask;
    logic [63:0] seen;
    logic [63:0] cand;
    int          fv [64];
    int          fn [64];
    int          depth;
    int          v;
    int          nxt;
    int          pick;
    mask        = scan_bits();
    seen        = 64'd1 << start;
    walk_seq[0] = start;
    walk_len    = 1;
    fv[0]       = int'(start);
    fn[0]       = 0;
    depth       = 1;
    while (depth > 0) begin
      v    = fv[depth-1];
      nxt  = fn[depth-1];
      cand = adj[v] & mask & ~seen;
      pick = 64;
      for (int j = 63; j >= nxt; j--) begin
        if (cand[j]) pick = j;
      end
      if (pick < 64 && depth < 64 && walk_len < 64) begin
        fn[depth-1]        = pick + 1;
        fv[depth]          = pick;
        fn[depth]          = 0;
        depth++;
        seen[pick]         = 1'b1;
        walk_seq[walk_len] = pick[gbt_pkg::VERT_W-1:0];
        walk_len++;
      end else begin
        depth--;
      end
    end
  endtask

  // vertices are marked when queued, the start when dequeued
  task automatic walk_breadth_first(input logic [gbt_pkg::VERT_W-1:0] start);
    logic [63:0]                mask;
    logic [63:0]                seen;
    logic [63:0]                cand;
    logic [gbt_pkg::VERT_W-1:0] ring [64];
    logic [gbt_pkg::VERT_W-1:0] head;
    logic [gbt_pkg::VERT_W-1:0] tail;
    logic [gbt_pkg::VERT_W-1:0] v;
    int                         queued;
    mask     = scan_bits();
    seen     = '0;
    head     = '0;
    ring[0]  = start;
    tail     = 6'd1;
    queued   = 1;
    walk_len = 0;
    while (queued > 0 && walk_len < 64) begin
      v    = ring[head];
      head = head + 1'b1;
      queued--;
      walk_seq[walk_len] = v;
      walk_len++;
      seen[v] = 1'b1;
      cand    = adj[v] & mask & ~seen;
      for (int j = 0; j < 64; j++) begin
        if (cand[j] && queued < 64) begin
          ring[tail] = j[gbt_pkg::VERT_W-1:0];
          tail       = tail + 1'b1;
          queued++;
          seen[j]    = 1'b1;
        end
      end
    end
  endtask

  function automatic void post_walk();
    visit_t e;
    for (int j = 0; j < walk_len; j++) begin
      e.vertex = walk_seq[j];
      e.last   = (j == walk_len - 1);
      visit_q.push_back(e);
    end
  endfunction

  task automatic apply_item(input logic [gbt_pkg::OP_W-1:0] code,
                            input logic [gbt_pkg::VERT_W-1:0] a,
                            input logic [gbt_pkg::VERT_W-1:0] b);
    case (code)
      gbt_pkg::OP_ADD_EDGE: begin
        adj[a][b] = 1'b1;
        adj[b][a] = 1'b1;
      end
      gbt_pkg::OP_REMOVE_EDGE: begin
        adj[a][b] = 1'b0;
        adj[b][a] = 1'b0;
      end
      gbt_pkg::OP_REMOVE_VERT: begin
        // only entries below vertex_count are cleared
        adj[a] = adj[a] & ~scan_bits();
        for (int j = 0; j < scan_limit(); j++) adj[j][a] = 1'b0;
      end
      gbt_pkg::OP_DFS: begin
        walk_depth_first(a);
        post_walk();
      end
      gbt_pkg::OP_BFS: begin
        walk_breadth_first(a);
        post_walk();
      end
      default: ;
    endcase
  endtask

  task automatic check_visit();
    visit_t want;
    if (visit_q.size() == 0) begin
      $display("%0t: result with none expected: expected none, actual vertex=%0d last=%0b",
               $time, vertex, last);
      mismatches++;
    end else begin
      want = visit_q.pop_front();
      if (vertex !== want.vertex) begin
        $display("%0t: vertex mismatch: expected %0d, actual %0d", $time, want.vertex, vertex);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 64; j++) adj[j] = '0;
      vcount = gbt_pkg::VCOUNT_RESET;
      visit_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) vcount = vertex_count;
      if (in_valid && in_ready) apply_item(op, vertex_a, vertex_b);
      if (out_valid && out_ready) check_visit();
    end
    pending = visit_q.size();
  end

endmodule

// ===== tb/sv/graph_bfs_dfs_traversal_tb.sv =====
// ---------------------------------------------------------------------------
// graph_bfs_dfs_traversal_tb
// Drives edge edits, vertex removals, ignored codes and DFS / BFS requests
// into the traversal block under several vertex_count settings, with random
// gaps on both channels; the checker predicts and compares, this module gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_bfs_dfs_traversal_tb;

  localparam int VW = gbt_pkg::VERT_W;
  localparam int CW = gbt_pkg::CNT_W;
  localparam int OW = gbt_pkg::OP_W;

  // block may still sweep (remove vertex) or flush after the last result
  localparam int DRAIN_CYCLES   = 200;
  // cycles with no accepted item on any channel before giving up
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 54;
  localparam int PHASES         = 6;

  // op codes the block ignores
  localparam logic [OW-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OW-1:0] OP_UNUSED_HI = 3'd7;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic [OW-1:0] op;
  logic [VW-1:0] vertex_a;
  logic [VW-1:0] vertex_b;
  logic          out_valid;
  logic          out_ready;
  logic [VW-1:0] vertex;
  logic          last;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [CW-1:0] vertex_count;

  int mismatches;
  int pending;
  int idle_cycles;
  bit send_quiet;

  graph_bfs_dfs_traversal dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex       (vertex),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .vertex_count (vertex_count)
  );

  gbt_visit_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex       (vertex),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .vertex_count (vertex_count),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: any accepted item on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: per item, ready may first be held low; now and then switch
  // to a no-stall stretch and back.
  initial begin
    int stall;
    bit recv_quiet;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_quiet = ~recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // One input item: optional gap with valid low, then hold until accepted.
  // Valid stays high on return so back-to-back items need no toggle.
  task automatic send_item(input logic [OW-1:0] o, input logic [VW-1:0] a,
                           input logic [VW-1:0] b);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    vertex_a <= a;
    vertex_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending, wait for every predicted result, then let the block go
  // idle (edits leave no result to wait on).
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // vertex_count is only written with the block idle
  task automatic set_vertex_count(input logic [CW-1:0] v);
    settle();
    cfg_valid    <= 1'b1;
    vertex_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // half the picks land in a narrow range so the graph gets dense there
  function automatic logic [VW-1:0] pick_vertex(input int span);
    if ($urandom_range(0, 1) == 0) return VW'($urandom_range(0, 63));
    return VW'($urandom_range(0, span));
  endfunction

  initial begin
    logic [CW-1:0] counts [PHASES];
    logic [OW-1:0] o;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    int            n;
    int            r;
    int            span;

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    op           <= gbt_pkg::OP_ADD_EDGE;
    vertex_a     <= '0;
    vertex_b     <= '0;
    cfg_valid    <= 1'b0;
    vertex_count <= gbt_pkg::VCOUNT_RESET;
    send_quiet   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, vertex_count at reset value 64 ---
    // empty graph: the start alone, flagged last
    send_item(gbt_pkg::OP_DFS, 6'd0, 6'd0);
    send_item(gbt_pkg::OP_BFS, 6'd63, 6'd63);
    // triangle 0-1-2, a tail to 63-62, a self loop on 5, 5 tied to 0 and 2
    send_item(gbt_pkg::OP_ADD_EDGE, 6'd0, 6'd1);
    send_item(gbt_pkg::OP_ADD_EDGE, 6'd1, 6'd2);
    send_item(gbt_pkg::OP_ADD_EDGE, 6'd0, 6'd2);
    send_item(gbt_pkg::OP_ADD_EDGE, 6'd2, 6'd63);
    send_item(gbt_pkg::OP_ADD_EDGE, 6'd5, 6'd5);
    send_item(gbt_pkg::OP_ADD_EDGE, 6'd5, 6'd2);
    send_item(gbt_pkg::OP_ADD_EDGE, 6'd63, 6'd62);
    send_item(gbt_pkg::OP_ADD_EDGE, 6'd5, 6'd0);
    send_item(gbt_pkg::OP_DFS, 6'd0, 6'd63);
    send_item(gbt_pkg::OP_BFS, 6'd0, 6'd63);
    send_item(gbt_pkg::OP_DFS, 6'd5, 6'd0);   // self loop must not revisit
    send_item(gbt_pkg::OP_BFS, 6'd63, 6'd0);
    // ignored codes
    send_item(OP_UNUSED_LO, 6'd63, 6'd63);
    send_item(OP_UNUSED_HI, 6'd0, 6'd0);
    send_item(gbt_pkg::OP_REMOVE_EDGE, 6'd0, 6'd2);
    send_item(gbt_pkg::OP_DFS, 6'd0, 6'd0);
    send_item(gbt_pkg::OP_REMOVE_VERT, 6'd2, 6'd0);
    send_item(gbt_pkg::OP_BFS, 6'd0, 6'd0);

    // vertex_count 0: nothing scanned, start still emitted
    set_vertex_count(7'd0);
    send_item(gbt_pkg::OP_DFS, 6'd10, 6'd0);

    // vertex_count 1: start above the count, only vertex 0 reachable
    set_vertex_count(7'd1);
    send_item(gbt_pkg::OP_DFS, 6'd5, 6'd0);
    send_item(gbt_pkg::OP_BFS, 6'd5, 6'd0);
    // removal clears only entries below the count; 63-62 stays
    send_item(gbt_pkg::OP_REMOVE_VERT, 6'd63, 6'd0);
    send_item(gbt_pkg::OP_BFS, 6'd62, 6'd0);

    // largest register value acts as 64
    set_vertex_count(7'd127);
    send_item(gbt_pkg::OP_DFS, 6'd63, 6'd0);

    // --- random phases, each under its own vertex_count ---
    counts[0] = 7'd64;
    counts[1] = 7'd16;
    counts[2] = 7'd127;
    counts[3] = 7'd5;
    counts[4] = CW'($urandom_range(2, 63));
    counts[5] = 7'd64;

    for (int p = 0; p < PHASES; p++) begin
      set_vertex_count(counts[p]);
      span       = (counts[p] > 7'd62) ? 63 : int'(counts[p]) + 1;
      send_quiet = (p == 2);   // one phase with no sender gaps
      n          = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        a = pick_vertex(span);
        b = pick_vertex(span);
        if (r < 45)      o = gbt_pkg::OP_ADD_EDGE;
        else if (r < 55) o = gbt_pkg::OP_REMOVE_EDGE;
        else if (r < 60) o = gbt_pkg::OP_REMOVE_VERT;
        else if (r < 75) o = gbt_pkg::OP_DFS;
        else if (r < 90) o = gbt_pkg::OP_BFS;
        else             o = OW'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        send_item(o, a, b);
        // ignored items do not count toward the phase
        if (o <= gbt_pkg::OP_BFS) begin
          n++;
          // mid-phase pause until every result is in
          if (p == 3 && n == PHASE_ITEMS / 2) settle();
        end
      end
    end

    settle();
    if (mismatches == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
